### hdl/skc_pkg.sv
`default_nettype none
package skc_pkg;

    localparam int FRAC = 16;
    localparam int CNT_EXT_W = 26;

    // controller steps; each also names the command the datapath executes
    localparam logic [4:0] OP_IDLE    = 5'd0;
    localparam logic [4:0] OP_CAPTURE = 5'd1;
    localparam logic [4:0] OP_SQX     = 5'd2;
    localparam logic [4:0] OP_SQY     = 5'd3;
    localparam logic [4:0] OP_SQZ     = 5'd4;
    localparam logic [4:0] OP_SQD     = 5'd5;
    localparam logic [4:0] OP_ROOT    = 5'd6;
    localparam logic [4:0] OP_QM      = 5'd7;
    localparam logic [4:0] OP_QC      = 5'd8;
    localparam logic [4:0] OP_X2      = 5'd9;
    localparam logic [4:0] OP_X3      = 5'd10;
    localparam logic [4:0] OP_ACC     = 5'd11;
    localparam logic [4:0] OP_C0      = 5'd12;
    localparam logic [4:0] OP_C1      = 5'd13;
    localparam logic [4:0] OP_C2      = 5'd14;
    localparam logic [4:0] OP_RS      = 5'd15;
    localparam logic [4:0] OP_D0      = 5'd16;
    localparam logic [4:0] OP_D1      = 5'd17;
    localparam logic [4:0] OP_SAL     = 5'd18;
    localparam logic [4:0] OP_EMIT    = 5'd19;
    localparam logic [4:0] OP_NONE    = 5'd20;

    localparam logic [2:0] REG_SENSOR_X  = 3'd0;
    localparam logic [2:0] REG_SENSOR_Y  = 3'd1;
    localparam logic [2:0] REG_SENSOR_Z  = 3'd2;
    localparam logic [2:0] REG_INV_SMOOTH = 3'd3;
    localparam logic [2:0] REG_SCALE     = 3'd4;
    localparam logic [2:0] REG_SAT_LEVEL = 3'd5;
    localparam logic [2:0] REG_REF_SAL   = 3'd6;
    localparam logic [2:0] REG_PLUME_SAL = 3'd7;

    localparam logic [31:0] ONE_Q32   = 32'h0001_0000;
    localparam logic [31:0] REF_RESET = 32'h0023_0000;

    typedef struct packed {
        logic [4:0] op;
    } cmd_t;

    typedef struct packed {
        logic last_item;
        logic root_done;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

### hdl/skc_ctrl.sv
`default_nettype none
module skc_ctrl
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_ready,
    input  wire skc_pkg::stat_t stat,
    output skc_pkg::cmd_t    cmd
);

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= skc_pkg::OP_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == skc_pkg::OP_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = state_reg;
        case (state_reg)
            skc_pkg::OP_IDLE:
            begin
                cmd.op = in_valid ? skc_pkg::OP_CAPTURE : skc_pkg::OP_NONE;
                if (in_valid)
                    state_next = skc_pkg::OP_SQX;
            end
            skc_pkg::OP_SQX:  state_next = skc_pkg::OP_SQY;
            skc_pkg::OP_SQY:  state_next = skc_pkg::OP_SQZ;
            skc_pkg::OP_SQZ:  state_next = skc_pkg::OP_SQD;
            skc_pkg::OP_SQD:  state_next = skc_pkg::OP_ROOT;
            skc_pkg::OP_ROOT:
            begin
                if (stat.root_done)
                    state_next = skc_pkg::OP_QM;
            end
            skc_pkg::OP_QM:   state_next = skc_pkg::OP_QC;
            skc_pkg::OP_QC:   state_next = skc_pkg::OP_X2;
            skc_pkg::OP_X2:   state_next = skc_pkg::OP_X3;
            skc_pkg::OP_X3:   state_next = skc_pkg::OP_ACC;
            skc_pkg::OP_ACC:
            begin
                state_next = stat.last_item ? skc_pkg::OP_C0 : skc_pkg::OP_IDLE;
            end
            skc_pkg::OP_C0:   state_next = skc_pkg::OP_C1;
            skc_pkg::OP_C1:   state_next = skc_pkg::OP_C2;
            skc_pkg::OP_C2:   state_next = skc_pkg::OP_RS;
            skc_pkg::OP_RS:   state_next = skc_pkg::OP_D0;
            skc_pkg::OP_D0:   state_next = skc_pkg::OP_D1;
            skc_pkg::OP_D1:   state_next = skc_pkg::OP_SAL;
            skc_pkg::OP_SAL:  state_next = skc_pkg::OP_EMIT;
            skc_pkg::OP_EMIT:
            begin
                cmd.op = stat.out_free ? skc_pkg::OP_EMIT : skc_pkg::OP_NONE;
                if (stat.out_free)
                    state_next = skc_pkg::OP_IDLE;
            end
            default:
            begin
                cmd.op     = skc_pkg::OP_NONE;
                state_next = skc_pkg::OP_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### hdl/skc_datapath.sv
`default_nettype none
module skc_datapath
#(
    parameter int MAX_PARTICLES_LOG2 = 20
)
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire skc_pkg::cmd_t     cmd,
    output skc_pkg::stat_t         stat,
    input  wire signed [31:0]      particle_x,
    input  wire signed [31:0]      particle_y,
    input  wire signed [31:0]      particle_z,
    input  wire                    last_particle,
    input  wire                    wr_en,
    input  wire [2:0]              wr_index,
    input  wire [31:0]             wr_data,
    output logic                   out_valid,
    input  wire                    out_ready,
    output logic [47:0]            concentration,
    output logic signed [47:0]     salinity,
    output logic [20:0]            particle_count,
    output logic                   overflow
);

    localparam int CNT_W = MAX_PARTICLES_LOG2 + 1;
    localparam int F = skc_pkg::FRAC;
    localparam int CNT_EXT_W_L = skc_pkg::CNT_EXT_W;

    // configuration
    logic signed [31:0] sensor_x_reg, sensor_y_reg, sensor_z_reg;
    logic [31:0] inv_reg, scale_reg, sat_reg, ref_reg, plume_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_x_reg <= '0;
            sensor_y_reg <= '0;
            sensor_z_reg <= '0;
            inv_reg      <= skc_pkg::ONE_Q32;
            scale_reg    <= skc_pkg::ONE_Q32;
            sat_reg      <= skc_pkg::ONE_Q32;
            ref_reg      <= skc_pkg::REF_RESET;
            plume_reg    <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                skc_pkg::REG_SENSOR_X:   sensor_x_reg <= wr_data;
                skc_pkg::REG_SENSOR_Y:   sensor_y_reg <= wr_data;
                skc_pkg::REG_SENSOR_Z:   sensor_z_reg <= wr_data;
                skc_pkg::REG_INV_SMOOTH: inv_reg      <= wr_data;
                skc_pkg::REG_SCALE:      scale_reg    <= wr_data;
                skc_pkg::REG_SAT_LEVEL:  sat_reg      <= wr_data;
                skc_pkg::REG_REF_SAL:    ref_reg      <= wr_data;
                skc_pkg::REG_PLUME_SAL:  plume_reg    <= wr_data;
                default: ;
            endcase
        end
    end

    // component magnitudes at capture
    logic signed [32:0] dx, dy, dz;
    logic [32:0] mx, my, mz;
    logic far;

    assign dx = 33'(particle_x) - 33'(sensor_x_reg);
    assign dy = 33'(particle_y) - 33'(sensor_y_reg);
    assign dz = 33'(particle_z) - 33'(sensor_z_reg);
    assign mx = dx[32] ? 33'(-dx) : 33'(dx);
    assign my = dy[32] ? 33'(-dy) : 33'(dy);
    assign mz = dz[32] ? 33'(-dz) : 33'(dz);
    // beyond 2^31 the squares would not fit: halve and double the root
    assign far = (mx > 33'h0_8000_0000) || (my > 33'h0_8000_0000)
              || (mz > 33'h0_8000_0000);

    logic [31:0] ax_reg, ay_reg, az_reg;
    logic half_reg, last_reg;

    // shared multiplier, product registered
    logic [32:0] mul_a, mul_b;
    logic [65:0] prod_reg;

    logic [63:0] acc_reg;
    logic [63:0] n_reg, r_reg, bit_reg;
    logic [4:0]  iter_reg;
    logic [16:0] x_reg, x2_reg;
    logic        inner_reg, kzero_reg;
    logic [18:0] kernel_reg;
    logic [39:0] sum_reg;
    logic [CNT_W-1:0] count_reg;
    logic        seen_reg;
    logic [79:0] wacc_reg;
    logic [63:0] rs_reg;
    logic [47:0] c_reg;
    logic        ovf_reg;
    logic signed [47:0] sal_reg;

    logic [32:0] d_val;
    logic [16:0] q_val, x_val, x2_val, x3_val;
    logic        qfar;
    logic [31:0] absdiff;
    logic        dneg;

    assign d_val   = half_reg ? {r_reg[31:0], 1'b0} : {1'b0, r_reg[31:0]};
    assign qfar    = |prod_reg[65:2*F+1];
    assign q_val   = prod_reg[2*F:F];
    assign x_val   = q_val[F] ? 17'(18'(2 << F) - 18'(q_val)) : q_val;
    assign x2_val  = prod_reg[2*F:F];
    assign x3_val  = prod_reg[2*F:F];
    assign dneg    = plume_reg < ref_reg;
    assign absdiff = dneg ? ref_reg - plume_reg : plume_reg - ref_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            skc_pkg::OP_SQX: begin mul_a = 33'(ax_reg); mul_b = 33'(ax_reg); end
            skc_pkg::OP_SQY: begin mul_a = 33'(ay_reg); mul_b = 33'(ay_reg); end
            skc_pkg::OP_SQZ: begin mul_a = 33'(az_reg); mul_b = 33'(az_reg); end
            skc_pkg::OP_QM:  begin mul_a = d_val; mul_b = 33'(inv_reg); end
            skc_pkg::OP_QC:  begin mul_a = 33'(x_val); mul_b = 33'(x_val); end
            skc_pkg::OP_X2:  begin mul_a = 33'(x2_val); mul_b = 33'(x_reg); end
            skc_pkg::OP_C0:  begin mul_a = 33'(scale_reg); mul_b = 33'(sum_reg[19:0]); end
            skc_pkg::OP_C1:  begin mul_a = 33'(scale_reg); mul_b = 33'(sum_reg[39:20]); end
            skc_pkg::OP_C2:  begin mul_a = 33'(ref_reg); mul_b = 33'(sat_reg); end
            skc_pkg::OP_RS:  begin mul_a = 33'(c_reg[23:0]); mul_b = 33'(absdiff); end
            skc_pkg::OP_D0:  begin mul_a = 33'(c_reg[47:24]); mul_b = 33'(absdiff); end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
        prod_reg <= mul_a * mul_b;

    // kernel and result arithmetic
    logic [63:0] rb;
    logic signed [22:0] kin;
    logic [18:0] kernel_next;
    logic [40:0] sum_wide;
    logic [71:0] cfull;
    logic [79:0] tfull;
    logic signed [81:0] stotal;
    logic signed [65:0] sshift;

    assign rb   = r_reg + bit_reg;
    assign kin  = 23'sd262144 - 23'sd6 * $signed({6'b0, x2_reg})
                + 23'sd3 * $signed({6'b0, x3_val});
    always_comb
    begin
        if (kzero_reg)
            kernel_next = '0;
        else if (inner_reg)
            kernel_next = kin[22] ? 19'd0 : kin[18:0];
        else
            kernel_next = 19'(x3_val);
    end
    assign sum_wide = {1'b0, sum_reg} + 41'(kernel_reg);
    assign cfull    = 72'(wacc_reg) + {prod_reg[51:0], 20'b0};
    assign tfull    = wacc_reg + {prod_reg[55:0], 24'b0};
    assign stotal   = dneg ? $signed(82'(rs_reg)) - $signed(82'(wacc_reg))
                           : $signed(82'(rs_reg)) + $signed(82'(wacc_reg));
    assign sshift   = 66'(stotal >>> F);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            seen_reg  <= 1'b0;
            iter_reg  <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cmd.op == skc_pkg::OP_EMIT)
                out_valid <= 1'b1;
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
            case (cmd.op)
                skc_pkg::OP_SQD:  iter_reg <= '0;
                skc_pkg::OP_ROOT: iter_reg <= iter_reg + 5'd1;
                skc_pkg::OP_ACC:
                begin
                    if (sum_wide[40])
                        sum_reg <= '1;
                    else
                        sum_reg <= sum_wide[39:0];
                    if (sum_wide[40] || count_reg[MAX_PARTICLES_LOG2])
                        seen_reg <= 1'b1;
                    if (!count_reg[MAX_PARTICLES_LOG2])
                        count_reg <= count_reg + CNT_W'(1);
                end
                skc_pkg::OP_EMIT:
                begin
                    sum_reg   <= '0;
                    count_reg <= '0;
                    seen_reg  <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    logic [CNT_EXT_W_L-1:0] cnt_ext;
    assign cnt_ext = {{(CNT_EXT_W_L-CNT_W){1'b0}}, count_reg};

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            skc_pkg::OP_CAPTURE:
            begin
                ax_reg   <= far ? mx[32:1] : mx[31:0];
                ay_reg   <= far ? my[32:1] : my[31:0];
                az_reg   <= far ? mz[32:1] : mz[31:0];
                half_reg <= far;
                last_reg <= last_particle;
            end
            skc_pkg::OP_SQY: acc_reg <= prod_reg[63:0];
            skc_pkg::OP_SQZ: acc_reg <= acc_reg + prod_reg[63:0];
            skc_pkg::OP_SQD:
            begin
                n_reg   <= acc_reg + prod_reg[63:0];
                r_reg   <= '0;
                bit_reg <= 64'h4000_0000_0000_0000;
            end
            skc_pkg::OP_ROOT:
            begin
                if (n_reg >= rb)
                begin
                    n_reg <= n_reg - rb;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                    r_reg <= r_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            skc_pkg::OP_QC:
            begin
                kzero_reg <= qfar;
                inner_reg <= ~q_val[F];
                x_reg     <= x_val;
            end
            skc_pkg::OP_X2: x2_reg <= x2_val;
            skc_pkg::OP_X3: kernel_reg <= kernel_next;
            skc_pkg::OP_C1: wacc_reg <= 80'(prod_reg[51:0]);
            skc_pkg::OP_C2:
            begin
                if (|cfull[71:64])
                begin
                    c_reg   <= '1;
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    c_reg   <= cfull[63:16];
                    ovf_reg <= seen_reg;
                end
            end
            skc_pkg::OP_RS: rs_reg <= prod_reg[63:0];
            skc_pkg::OP_D0: wacc_reg <= 80'(prod_reg[55:0]);
            skc_pkg::OP_D1: wacc_reg <= tfull;
            skc_pkg::OP_SAL:
            begin
                if (!sshift[65] && (|sshift[64:47]))
                begin
                    sal_reg <= 48'sh7FFF_FFFF_FFFF;
                    ovf_reg <= 1'b1;
                end
                else if (sshift[65] && !(&sshift[64:47]))
                begin
                    sal_reg <= 48'sh8000_0000_0000;
                    ovf_reg <= 1'b1;
                end
                else
                    sal_reg <= sshift[47:0];
            end
            skc_pkg::OP_EMIT:
            begin
                concentration  <= c_reg;
                salinity       <= sal_reg;
                particle_count <= cnt_ext[20:0];
                overflow       <= ovf_reg;
            end
            default: ;
        endcase
    end

    assign stat.last_item = last_reg;
    assign stat.root_done = (iter_reg == 5'd31);
    assign stat.out_free  = !out_valid || out_ready;

endmodule
`default_nettype wire

### hdl/sph_kernel_concentration_sum.sv
// Particle items are taken only in idle, one finished before the next: capture,
// three squarings on the shared multiplier, a 32-step square root (one result
// bit per cycle), then the kernel. After the last particle's item the result
// steps run; it waits in the output register while the next cloud is taken in.
// rst_n (asynchronous, active low) clears the sum, count, seen flag and handshakes
// and loads the register defaults; no clearing pass is needed.
`default_nettype none
module sph_kernel_concentration_sum
#(
    parameter int MAX_PARTICLES_LOG2 = 20
)
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [95:0]  s_axis_tdata,   // particle_x, particle_y, particle_z
    input  wire          s_axis_tlast,   // last_particle
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [119:0] m_axis_tdata,   // concentration, salinity, particle_count, overflow
    input  wire          wr_en,
    input  wire  [2:0]   wr_index,
    input  wire  [31:0]  wr_data
);

    skc_pkg::cmd_t  cmd;
    skc_pkg::stat_t stat;

    logic [47:0]        concentration;
    logic signed [47:0] salinity;
    logic [20:0]        particle_count;
    logic               overflow;

    skc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    skc_datapath #(.MAX_PARTICLES_LOG2(MAX_PARTICLES_LOG2)) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .particle_x     (s_axis_tdata[31:0]),
        .particle_y     (s_axis_tdata[63:32]),
        .particle_z     (s_axis_tdata[95:64]),
        .last_particle  (s_axis_tlast),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .concentration  (concentration),
        .salinity       (salinity),
        .particle_count (particle_count),
        .overflow       (overflow)
    );

    assign m_axis_tdata = {2'b00, overflow, particle_count, salinity, concentration};

endmodule
`default_nettype wire
